[rtl/rfr_pkg.sv]
// ----------------------------------------------------------------------------
// rfr_pkg: shared types and constants
// Beat formats and command format for the RTP fragment reassembler.
// ----------------------------------------------------------------------------
package rfr_pkg;

    // Function codes of an input beat
    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // Fragment codes
    localparam logic [7:0] FRAG_START  = 8'd1;
    localparam logic [7:0] FRAG_MIDDLE = 8'd2;
    localparam logic [7:0] FRAG_END    = 8'd3;

    // Widest store address over the whole frame-size range (two halves of 64 KiB)
    localparam int unsigned ADDR_W_MAX = 17;
    localparam int unsigned HDR_W      = 19;

    typedef struct packed {
        logic       func;
        logic [7:0] in_byte;
        logic       in_last;
    } rfr_in_t;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       out_frame_end;
        logic       frame_ready;
        logic       group_discarded;
    } rfr_out_t;

    // Flags of a result decided by the front end
    typedef struct packed {
        logic out_valid;
        logic out_frame_end;
        logic frame_ready;
        logic group_discarded;
    } rfr_flags_t;

    // Command from front end to back end: one store access plus result flags
    typedef struct packed {
        logic                  write;
        logic [ADDR_W_MAX-1:0] addr;
        logic [7:0]            data;
        rfr_flags_t            flags;
    } rfr_cmd_t;

endpackage

[rtl/rfr_fifo.sv]
// ----------------------------------------------------------------------------
// rfr_fifo: small register queue
// Holds beats between two stages; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module rfr_fifo #(
    parameter type T = logic,
    parameter int unsigned DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr,
    input  T                           wdata,
    output logic                       full,
    input  logic                       rd,
    output T                           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    T                slot_reg [DEPTH];
    logic [PW-1:0]   wptr_reg;
    logic [PW-1:0]   rptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_wr;
    logic            do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign count = count_reg;
    assign rdata = slot_reg[rptr_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

[rtl/rfr_front.sv]
// ----------------------------------------------------------------------------
// rfr_front: header parser and group tracker
// Parses each packet beat, tracks groups and fragments, and issues one store
// command per accepted beat.
// ----------------------------------------------------------------------------
module rfr_front #(
    parameter int unsigned MAX_FRAME_BYTES = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  rfr_pkg::rfr_in_t  item,
    output rfr_pkg::rfr_cmd_t cmd
);
    import rfr_pkg::*;

    localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);

    logic [15:0]      pos_reg,      pos_next;
    logic [HDR_W-1:0] hl_reg,       hl_next;
    logic [15:0]      seq_reg,      seq_next;
    logic [31:0]      stamp_reg,    stamp_next;
    logic [31:0]      gstamp_reg,   gstamp_next;
    logic             open_reg,     open_next;
    logic             run_reg,      run_next;
    logic             prev_reg,     prev_next;
    logic [15:0]      exp_reg,      exp_next;
    logic             err_reg,      err_next;
    logic [CW-1:0]    collect_reg,  collect_next;
    logic [CW-1:0]    ready_reg,    ready_next;
    logic [CW-1:0]    dptr_reg,     dptr_next;
    logic             half_reg,     half_next;
    logic             ext_reg,      ext_next;
    logic [7:0]       exthi_reg,    exthi_next;
    logic             long_reg,     long_next;

    logic [HDR_W-1:0]      cur_w;
    logic                  follows;
    logic                  bad;
    logic [ADDR_W_MAX-1:0] base;

    always_comb
    begin
        pos_next     = pos_reg;
        hl_next      = hl_reg;
        seq_next     = seq_reg;
        stamp_next   = stamp_reg;
        gstamp_next  = gstamp_reg;
        open_next    = open_reg;
        run_next     = run_reg;
        prev_next    = prev_reg;
        exp_next     = exp_reg;
        err_next     = err_reg;
        collect_next = collect_reg;
        ready_next   = ready_reg;
        dptr_next    = dptr_reg;
        half_next    = half_reg;
        ext_next     = ext_reg;
        exthi_next   = exthi_reg;
        long_next    = long_reg;
        cmd          = '0;
        cur_w        = HDR_W'(pos_reg);
        follows      = 1'b0;
        bad          = 1'b0;
        base         = '0;

        if (item.func == FUNC_PUSH)
        begin
            if (long_reg)
            begin
                err_next = 1'b1;
            end
            else
            begin
                // Capture header fields
                if (pos_reg == 16'd0)
                begin
                    hl_next  = HDR_W'(12) + HDR_W'({item.in_byte[3:0], 2'b00});
                    ext_next = item.in_byte[4];
                    if (item.in_byte[4])
                    begin
                        hl_next = hl_next + HDR_W'(4);
                    end
                end
                else if (pos_reg == 16'd2)
                begin
                    seq_next = {item.in_byte, 8'h00};
                end
                else if (pos_reg == 16'd3)
                begin
                    seq_next = {seq_reg[15:8], item.in_byte};
                end
                else if (pos_reg >= 16'd4 && pos_reg <= 16'd7)
                begin
                    stamp_next = {stamp_reg[23:0], item.in_byte};
                end

                // Packet accepted: close old group on a new timestamp, open new one
                if (pos_reg == 16'd11)
                begin
                    if (!open_reg || (gstamp_reg != stamp_reg))
                    begin
                        if (open_reg)
                        begin
                            if (err_reg)
                            begin
                                cmd.flags.group_discarded = 1'b1;
                            end
                            else if (collect_reg != '0)
                            begin
                                if (ready_reg != '0)
                                begin
                                    cmd.flags.group_discarded = 1'b1;
                                end
                                else
                                begin
                                    ready_next = collect_reg;
                                    dptr_next  = '0;
                                    half_next  = ~half_reg;
                                end
                            end
                        end
                        open_next    = 1'b1;
                        gstamp_next  = stamp_reg;
                        err_next     = 1'b0;
                        run_next     = 1'b0;
                        prev_next    = 1'b0;
                        exp_next     = '0;
                        collect_next = '0;
                    end
                end

                // Extend header length by the extension word count
                if (ext_reg && pos_reg >= 16'd12)
                begin
                    if (cur_w + HDR_W'(2) == hl_reg)
                    begin
                        exthi_next = item.in_byte;
                    end
                    else if (cur_w + HDR_W'(1) == hl_reg)
                    begin
                        hl_next  = hl_reg + HDR_W'({exthi_reg, item.in_byte, 2'b00});
                        ext_next = 1'b0;
                    end
                end

                // Check fragment code, then store payload
                if (pos_reg >= 16'd12)
                begin
                    if (cur_w == hl_next)
                    begin
                        if (!err_next)
                        begin
                            follows = prev_next && (seq_next == exp_next);
                            case (item.in_byte)
                                FRAG_START:
                                begin
                                    bad = run_next;
                                    if (!bad)
                                    begin
                                        run_next = 1'b1;
                                    end
                                end
                                FRAG_MIDDLE:
                                begin
                                    bad = !run_next || !follows;
                                end
                                FRAG_END:
                                begin
                                    run_next = 1'b0;
                                    bad      = !follows;
                                end
                                default:
                                begin
                                    bad = 1'b1;
                                end
                            endcase
                            if (bad)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                prev_next = 1'b1;
                                exp_next  = seq_next + 16'd1;
                            end
                        end
                    end
                    else if (cur_w > hl_next && !err_next)
                    begin
                        if (collect_next >= CW'(MAX_FRAME_BYTES))
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            base         = half_next ? ADDR_W_MAX'(MAX_FRAME_BYTES) : '0;
                            cmd.write    = 1'b1;
                            cmd.addr     = base + ADDR_W_MAX'(collect_next);
                            cmd.data     = item.in_byte;
                            collect_next = collect_next + 1'b1;
                        end
                    end
                end

                // Advance byte position, flag overlong packet
                if (pos_reg == 16'hFFFF)
                begin
                    long_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + 16'd1;
                end
            end

            // End of packet: flag truncated header, rewind parser
            if (item.in_last)
            begin
                if (pos_reg >= 16'd11 && cur_w < hl_next)
                begin
                    err_next = 1'b1;
                end
                pos_next   = '0;
                hl_next    = HDR_W'(12);
                ext_next   = 1'b0;
                exthi_next = '0;
                long_next  = 1'b0;
            end
        end
        else if (ready_reg != '0)
        begin
            // Drain one byte from the published half
            base                = half_reg ? '0 : ADDR_W_MAX'(MAX_FRAME_BYTES);
            cmd.addr            = base + ADDR_W_MAX'(dptr_reg);
            cmd.flags.out_valid = 1'b1;
            dptr_next           = dptr_reg + 1'b1;
            if (dptr_next == ready_reg)
            begin
                cmd.flags.out_frame_end = 1'b1;
                ready_next              = '0;
                dptr_next               = '0;
            end
        end

        cmd.flags.frame_ready = (ready_next != '0);
    end

    // Hold parser and group state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            hl_reg      <= HDR_W'(12);
            seq_reg     <= '0;
            stamp_reg   <= '0;
            gstamp_reg  <= '0;
            open_reg    <= 1'b0;
            run_reg     <= 1'b0;
            prev_reg    <= 1'b0;
            exp_reg     <= '0;
            err_reg     <= 1'b0;
            collect_reg <= '0;
            ready_reg   <= '0;
            dptr_reg    <= '0;
            half_reg    <= 1'b0;
            ext_reg     <= 1'b0;
            exthi_reg   <= '0;
            long_reg    <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg     <= pos_next;
            hl_reg      <= hl_next;
            seq_reg     <= seq_next;
            stamp_reg   <= stamp_next;
            gstamp_reg  <= gstamp_next;
            open_reg    <= open_next;
            run_reg     <= run_next;
            prev_reg    <= prev_next;
            exp_reg     <= exp_next;
            err_reg     <= err_next;
            collect_reg <= collect_next;
            ready_reg   <= ready_next;
            dptr_reg    <= dptr_next;
            half_reg    <= half_next;
            ext_reg     <= ext_next;
            exthi_reg   <= exthi_next;
            long_reg    <= long_next;
        end
    end
endmodule

[rtl/rfr_back.sv]
// ----------------------------------------------------------------------------
// rfr_back: frame store and result queue
// Carries out store commands in order and queues the result beats.
// ----------------------------------------------------------------------------
module rfr_back #(
    parameter int unsigned MAX_FRAME_BYTES = 4096,
    parameter int unsigned OUT_DEPTH       = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rfr_pkg::rfr_cmd_t cmd,
    input  logic              cmd_empty,
    output logic              cmd_pop,
    input  logic              pop,
    output logic              empty,
    output rfr_pkg::rfr_out_t out_item
);
    import rfr_pkg::*;

    localparam int unsigned SD  = 2 * MAX_FRAME_BYTES;
    localparam int unsigned AW  = $clog2(SD);
    localparam int unsigned OCW = $clog2(OUT_DEPTH + 1);

    logic [7:0]       mem [SD];
    logic [7:0]       rd_reg;
    logic             s_valid_reg;
    rfr_flags_t       s_flags_reg;
    logic [OCW-1:0]   out_count;
    logic             out_full;
    rfr_out_t         res;

    // Issue a command only when the result queue has room for it
    assign cmd_pop = !cmd_empty && !out_full &&
                     ((OCW'(out_count) + OCW'(s_valid_reg)) < OCW'(OUT_DEPTH));

    // Write or read the frame store
    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.write)
        begin
            mem[cmd.addr[AW-1:0]] <= cmd.data;
        end
        rd_reg <= mem[cmd.addr[AW-1:0]];
        s_flags_reg <= cmd.flags;
    end

    // Track the store stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= cmd_pop;
        end
    end

    // Form the result beat
    always_comb
    begin
        res.out_valid       = s_flags_reg.out_valid;
        res.out_byte        = s_flags_reg.out_valid ? rd_reg : 8'h00;
        res.out_frame_end   = s_flags_reg.out_frame_end;
        res.frame_ready     = s_flags_reg.frame_ready;
        res.group_discarded = s_flags_reg.group_discarded;
    end

    rfr_fifo #(
        .T     (rfr_out_t),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (s_valid_reg),
        .wdata (res),
        .full  (out_full),
        .rd    (pop),
        .rdata (out_item),
        .empty (empty),
        .count (out_count)
    );
endmodule

[rtl/rtp_fragment_reassembler.sv]
// A result beat passes through the command queue, the frame-store read register and the result queue.
// Throughput: one input beat per cycle while the queues have room, one result beat per input beat.
// The pace is set by the single frame-store port, one access per beat.
// Reset: control state clears at once; the frame store is not cleared and
// needs no clearing pass, so beats are taken right after reset.
// ----------------------------------------------------------------------------
// rtp_fragment_reassembler: RTP fragment reassembler top level
// Parses packet bytes, groups fragments by timestamp and drains frames.
// ----------------------------------------------------------------------------
module rtp_fragment_reassembler #(
    parameter int unsigned MAX_FRAME_BYTES = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  rfr_pkg::rfr_in_t  in_item,
    output logic              empty,
    input  logic              pop,
    output rfr_pkg::rfr_out_t out_item
);
    import rfr_pkg::*;

    rfr_cmd_t   fcmd;
    rfr_cmd_t   qcmd;
    logic       accept;
    logic       cmd_empty;
    logic       cmd_pop;
    logic [1:0] cmd_count;

    assign accept = push && !full;

    rfr_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_item),
        .cmd    (fcmd)
    );

    // Decouple front end from back end
    rfr_fifo #(
        .T     (rfr_cmd_t),
        .DEPTH (2)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (accept),
        .wdata (fcmd),
        .full  (full),
        .rd    (cmd_pop),
        .rdata (qcmd),
        .empty (cmd_empty),
        .count (cmd_count)
    );

    rfr_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .OUT_DEPTH       (4)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (qcmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .out_item  (out_item)
    );

`ifndef SYNTHESIS
    a_end_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.out_frame_end) |-> out_item.out_valid)
        else $error("frame end without valid byte");
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.out_frame_end) |-> !out_item.frame_ready)
        else $error("frame still ready after its last byte");
    a_idle_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_item.out_valid) |-> (out_item.out_byte == 8'h00))
        else $error("byte present on empty drain");
    a_cmd_count: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (cmd_count == 2'd2))
        else $error("command queue full flag mismatch");
`endif
endmodule

[bench/rtp_fragment_reassembler_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_fragment_reassembler_test: self-checking bench for the reassembler
// Sends RTP packets and drain requests one beat at a time. Every accepted
// beat is run through a local model of the parser, grouping and drain logic,
// and the result beats that come out are compared against it in order.
// ----------------------------------------------------------------------------
module rtp_fragment_reassembler_test;
    import rfr_pkg::*;

    localparam int unsigned FRAME_BYTES = 4096;

    logic     clk;
    logic     rst_n;
    logic     push;
    logic     full;
    rfr_in_t  in_item;
    logic     empty;
    logic     pop;
    rfr_out_t out_item;

    rtp_fragment_reassembler #(.MAX_FRAME_BYTES(FRAME_BYTES)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    // Model state
    logic [7:0]  frame_mem [0:2*FRAME_BYTES-1];
    int unsigned pos;
    int unsigned hdr_len;
    logic [15:0] pkt_seq;
    logic [31:0] pkt_ts;
    logic [31:0] grp_ts;
    logic        grp_open;
    logic        run_open;
    logic        have_prev;
    logic [15:0] next_seq;
    logic        grp_err;
    int unsigned coll_len;
    int unsigned rdy_len;
    int unsigned drain_ptr;
    logic        act_half;
    logic        ext_pend;
    logic [7:0]  ext_high;
    logic        pkt_long;

    rfr_out_t    expected_beats[$];
    int          errors;
    int          beats_sent;
    int          results_seen;
    int          frames_seen;
    int          discards_seen;
    int          hold_cycles;
    bit          fast;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Model: open a fresh timestamp group
    function automatic void open_group();
        grp_open  = 1'b1;
        grp_ts    = pkt_ts;
        grp_err   = 1'b0;
        run_open  = 1'b0;
        have_prev = 1'b0;
        next_seq  = '0;
        coll_len  = 0;
    endfunction

    // Model: close the group, return 1 when it is dropped with a pulse
    function automatic logic close_group();
        if (grp_err)
            return 1'b1;
        if (coll_len == 0)
            return 1'b0;
        if (rdy_len != 0)
            return 1'b1;
        rdy_len   = coll_len;
        drain_ptr = 0;
        act_half  = ~act_half;
        return 1'b0;
    endfunction

    // Model: check the fragment code against the run and sequence
    function automatic void check_code(logic [7:0] code);
        logic follows;
        logic bad;
        follows = have_prev && (pkt_seq == next_seq);
        if (grp_err)
            return;
        if (code == FRAG_START) begin
            bad = run_open;
            if (!bad)
                run_open = 1'b1;
        end
        else if (code == FRAG_MIDDLE) begin
            bad = !run_open || !follows;
        end
        else if (code == FRAG_END) begin
            run_open = 1'b0;
            bad = !follows;
        end
        else begin
            bad = 1'b1;
        end
        if (bad) begin
            grp_err = 1'b1;
            return;
        end
        have_prev = 1'b1;
        next_seq  = pkt_seq + 16'd1;
    endfunction

    // Model: expected result for one accepted beat
    function automatic rfr_out_t reassemble_beat(rfr_in_t it);
        rfr_out_t    r;
        int unsigned cur;
        logic [7:0]  b;
        r   = '0;
        b   = it.in_byte;
        cur = pos;
        if (it.func == FUNC_PUSH) begin
            if (pkt_long) begin
                grp_err = 1'b1;
            end
            else begin
                if (cur == 0) begin
                    hdr_len  = 12 + 4 * b[3:0];
                    ext_pend = b[4];
                    if (ext_pend)
                        hdr_len += 4;
                end
                else if (cur == 2)
                    pkt_seq = {b, 8'h00};
                else if (cur == 3)
                    pkt_seq[7:0] = b;
                else if (cur >= 4 && cur <= 7)
                    pkt_ts = {pkt_ts[23:0], b};
                // Compare timestamp on the 12th byte
                if (cur == 11) begin
                    if (!grp_open)
                        open_group();
                    else if (grp_ts != pkt_ts) begin
                        r.group_discarded = close_group();
                        open_group();
                    end
                end
                // Pick up the extension length
                if (ext_pend && cur >= 12) begin
                    if (cur + 2 == hdr_len)
                        ext_high = b;
                    else if (cur + 1 == hdr_len) begin
                        hdr_len += 4 * {ext_high, b};
                        ext_pend = 1'b0;
                    end
                end
                if (cur >= 12) begin
                    if (cur == hdr_len)
                        check_code(b);
                    else if (cur > hdr_len && !grp_err) begin
                        if (coll_len >= FRAME_BYTES)
                            grp_err = 1'b1;
                        else begin
                            frame_mem[act_half * FRAME_BYTES + coll_len] = b;
                            coll_len++;
                        end
                    end
                end
                if (cur == 16'hFFFF)
                    pkt_long = 1'b1;
                else
                    pos = cur + 1;
            end
            if (it.in_last) begin
                if (cur >= 11 && cur < hdr_len)
                    grp_err = 1'b1;
                pos      = 0;
                hdr_len  = 12;
                ext_pend = 1'b0;
                ext_high = '0;
                pkt_long = 1'b0;
            end
        end
        else if (rdy_len != 0 && drain_ptr < rdy_len) begin
            r.out_valid = 1'b1;
            r.out_byte  = frame_mem[(act_half ^ 1'b1) * FRAME_BYTES + drain_ptr];
            drain_ptr++;
            if (drain_ptr == rdy_len) begin
                r.out_frame_end = 1'b1;
                rdy_len   = 0;
                drain_ptr = 0;
            end
        end
        r.frame_ready = (rdy_len != 0);
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch: %s got %0h expected %0h (result %0d)", what, got, want,
                 results_seen);
        errors++;
    endtask

    // Send one beat and predict its result once accepted
    task automatic send_beat(logic func, logic [7:0] b, logic last);
        int     gap;
        bit     taken;
        rfr_in_t it;
        gap = fast ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        it.func    = func;
        it.in_byte = b;
        it.in_last = last;
        push    = 1'b1;
        in_item = it;
        do begin
            taken = !full;
            @(negedge clk);
        end while (!taken);
        expected_beats.insert(expected_beats.size(), reassemble_beat(it));
        beats_sent++;
    endtask

    task automatic drain(int n);
        repeat (n) send_beat(FUNC_DRAIN, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
    endtask

    // Build and send one packet; cut > 0 truncates it to that many bytes
    task automatic send_packet(int cc, bit ext, int ext_words, logic [15:0] seq,
                               logic [31:0] ts, logic [7:0] code, int plen, int cut = 0);
        logic [7:0] pkt[$];
        int         n;
        pkt.insert(pkt.size(), {2'b10, 1'b0, ext, cc[3:0]});
        pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
        pkt.insert(pkt.size(), seq[15:8]);
        pkt.insert(pkt.size(), seq[7:0]);
        for (int i = 3; i >= 0; i--)
            pkt.insert(pkt.size(), ts[8*i +: 8]);
        repeat (4 + 4 * cc) pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
        if (ext) begin
            pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
            pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
            pkt.insert(pkt.size(), ext_words[15:8]);
            pkt.insert(pkt.size(), ext_words[7:0]);
            repeat (4 * ext_words) pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
        end
        pkt.insert(pkt.size(), code);
        repeat (plen) pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
        n = (cut > 0 && cut < pkt.size()) ? cut : pkt.size();
        for (int i = 0; i < n; i++)
            send_beat(FUNC_PUSH, pkt[i], i == n - 1);
    endtask

    // Pause the sender until every expected result has come back
    task automatic settle();
        push = 1'b0;
        while (expected_beats.size() != 0)
            @(negedge clk);
    endtask

    // Check each result beat against the oldest expectation
    initial begin
        rfr_out_t got;
        rfr_out_t want;
        int       gap;
        bit       seen;
        pop = 1'b0;
        @(posedge rst_n);
        forever begin
            gap = fast ? 0 : $urandom_range(0, 6);
            if (hold_cycles > 0) begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            if (gap > 0) begin
                pop = 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop = 1'b1;
            do begin
                seen = !empty;
                got  = out_item;
                @(negedge clk);
            end while (!seen);
            results_seen++;
            if (expected_beats.size() == 0) begin
                report("unexpected result", 1, 0);
            end
            else begin
                want = expected_beats.pop_front();
                if (got.out_valid !== want.out_valid)
                    report("out_valid", got.out_valid, want.out_valid);
                if (got.out_byte !== want.out_byte)
                    report("out_byte", got.out_byte, want.out_byte);
                if (got.out_frame_end !== want.out_frame_end)
                    report("out_frame_end", got.out_frame_end, want.out_frame_end);
                if (got.frame_ready !== want.frame_ready)
                    report("frame_ready", got.frame_ready, want.frame_ready);
                if (got.group_discarded !== want.group_discarded)
                    report("group_discarded", got.group_discarded, want.group_discarded);
                if (want.out_frame_end)
                    frames_seen++;
                if (want.group_discarded)
                    discards_seen++;
            end
        end
    end

    // Directed: drains, short and well-formed groups, wrap, busy drain
    task automatic test_basic();
        drain(1);
        send_packet(0, 1'b0, 0, 16'd0, 32'd0, FRAG_START, 0, 5);
        send_packet(1, 1'b1, 1, 16'd10, 32'd0, FRAG_START, 3);
        send_packet(0, 1'b0, 0, 16'd11, 32'd0, FRAG_MIDDLE, 2);
        send_packet(0, 1'b0, 0, 16'd12, 32'd0, FRAG_END, 4);
        send_packet(15, 1'b0, 0, 16'hFFFF, 32'hFFFF_FFFF, FRAG_START, 2);
        send_packet(0, 1'b0, 0, 16'h0000, 32'hFFFF_FFFF, FRAG_END, 1);
        send_packet(0, 1'b0, 0, 16'd5, 32'd7, FRAG_START, 1);
        drain(14);
    endtask

    // Directed: every fragment error and truncated or empty packets
    task automatic test_errors();
        send_packet(0, 1'b0, 0, 16'd1, 32'd20, FRAG_START, 2);
        send_packet(0, 1'b0, 0, 16'd2, 32'd20, FRAG_START, 2);
        send_packet(0, 1'b0, 0, 16'd1, 32'd21, FRAG_MIDDLE, 2);
        send_packet(0, 1'b0, 0, 16'd1, 32'd22, 8'd0, 2);
        send_packet(0, 1'b0, 0, 16'd1, 32'd23, 8'hFF, 2);
        send_packet(0, 1'b0, 0, 16'd1, 32'd24, FRAG_START, 2);
        send_packet(0, 1'b0, 0, 16'd3, 32'd24, FRAG_END, 2);
        send_packet(2, 1'b0, 0, 16'd1, 32'd25, FRAG_START, 2, 12);
        send_packet(0, 1'b1, 2, 16'd1, 32'd26, FRAG_START, 2, 15);
        send_packet(0, 1'b0, 0, 16'd1, 32'd27, FRAG_START, 0);
        send_packet(0, 1'b0, 0, 16'd1, 32'd28, FRAG_START, 1);
        drain(3);
    endtask

    // Directed: a longer frame sent and drained with no idle cycles
    task automatic test_long_frame();
        fast = 1'b1;
        send_packet(0, 1'b0, 0, 16'd100, 32'd40, FRAG_START, 40);
        send_packet(0, 1'b0, 0, 16'd101, 32'd40, FRAG_END, 40);
        send_packet(0, 1'b0, 0, 16'd1, 32'd41, FRAG_START, 1);
        drain(82);
        fast = 1'b0;
        settle();
    endtask

    // Receiver holds off while packets keep coming, so the input stalls
    task automatic test_backpressure();
        hold_cycles = 300;
        repeat (6) begin
            send_packet($urandom_range(0, 3), 1'b0, 0, 16'd9, 32'd50, FRAG_START, 12);
            drain(4);
        end
        settle();
    endtask

    // Random: mostly well-formed groups, some noise and broken sequences
    task automatic test_random(int n_beats);
        int          stop;
        logic [15:0] seq;
        logic [31:0] ts;
        int          frags;
        logic [7:0]  code;
        stop = beats_sent + n_beats;
        seq  = 16'($urandom);
        ts   = $urandom;
        while (beats_sent < stop) begin
            ts    = ($urandom_range(0, 9) == 0) ? $urandom : ts + 1;
            frags = $urandom_range(1, 4);
            for (int f = 0; f < frags; f++) begin
                code = (f == 0) ? FRAG_START : (f == frags - 1) ? FRAG_END : FRAG_MIDDLE;
                case ($urandom_range(0, 19))
                    0: code = 8'($urandom_range(0, 255));
                    1: seq += 16'd2;
                    2: begin
                        send_packet(0, 1'b0, 0, seq, ts, code, 0, $urandom_range(1, 11));
                        continue;
                    end
                    default: ;
                endcase
                send_packet($urandom_range(0, 2), 1'($urandom_range(0, 1)),
                            $urandom_range(0, 2),
                            seq, ts, code, $urandom_range(0, 20),
                            ($urandom_range(0, 24) == 0) ? $urandom_range(12, 20) : 0);
                seq++;
            end
            drain($urandom_range(0, 30));
            if ($urandom_range(0, 29) == 0)
                settle();
        end
        drain(45);
    endtask

    initial begin
        errors        = 0;
        beats_sent    = 0;
        results_seen  = 0;
        frames_seen   = 0;
        discards_seen = 0;
        hold_cycles   = 0;
        fast          = 1'b0;
        push          = 1'b0;
        in_item       = '0;
        pos       = 0;
        hdr_len   = 12;
        pkt_seq   = '0;
        pkt_ts    = '0;
        grp_ts    = '0;
        grp_open  = 1'b0;
        run_open  = 1'b0;
        have_prev = 1'b0;
        next_seq  = '0;
        grp_err   = 1'b0;
        coll_len  = 0;
        rdy_len   = 0;
        drain_ptr = 0;
        act_half  = 1'b0;
        ext_pend  = 1'b0;
        ext_high  = '0;
        pkt_long  = 1'b0;
        rst_n     = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_basic();
        test_errors();
        test_backpressure();
        test_long_frame();
        test_random(300);

        settle();
        repeat (10) @(negedge clk);
        $display("covered %0d beats, %0d results, %0d frames drained, %0d groups dropped",
                 beats_sent, results_seen, frames_seen, discards_seen);
        if (errors == 0 && expected_beats.size() == 0)
            $display("[rtp_fragment_reassembler] OK");
        else
            $display("[rtp_fragment_reassembler] ERROR");
        $finish;
    end

    // Give up on a hung run
    initial begin
        #15ms;
        $display("timeout with %0d results outstanding", expected_beats.size());
        $display("[rtp_fragment_reassembler] ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/rfr_pkg.sv
rtl/rfr_fifo.sv
rtl/rfr_front.sv
rtl/rfr_back.sv
rtl/rtp_fragment_reassembler.sv
bench/rtp_fragment_reassembler_test.sv
